FILE: rtl/prt_pkg.sv
// Shared types and constants for the pending reply tracker.
package prt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int HANDLE_BITS = 8;
   localparam int OPCODE_BITS = 8;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_ADD       = 2'd0,
      KIND_SEARCH    = 2'd1,
      KIND_SET_READY = 2'd2,
      KIND_CHECK     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [OPCODE_BITS-1:0] opcode;
      logic                   ready;
   } entry_type;

   typedef struct packed {
      kind_type               kind;
      logic [HANDLE_BITS-1:0] handle;
      logic [OPCODE_BITS-1:0] opcode;
   } key_type;

endpackage

FILE: rtl/prt_entry_cmp.sv
// Shared compare unit: tests one table entry against the held request.
module prt_entry_cmp
   import prt_pkg::*;
(
   input  entry_type entry,
   input  key_type   key,
   output logic      hit
);

   always_comb begin
      case (key.kind)
         KIND_SEARCH: hit = entry.ready || (entry.opcode == key.opcode);
         default:     hit = (entry.handle == key.handle);
      endcase
   end

endmodule

FILE: rtl/pending_reply_tracker.sv
// Top level of the pending reply tracker: ordered table, scan sequencer, compaction.
//
// Usage: drive req_kind, req_handle and req_opcode with start high; the beat
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the answer is out. Exactly one result comes back per request,
// shown on the rsp_ ports for one cycle with rsp_valid high; there is no
// back-pressure, the receiver must take it then.
//
// Timing: every request walks the table one entry per cycle through a single
// compare unit fed by the registered memory read port. A check that removes an
// entry then shifts the later entries down one slot per cycle through the
// same memory port. busy drops in the cycle the result is shown, so a new
// request may be taken in that cycle.
//
// Reset empties the table (entry count to zero) and returns the sequencer to
// idle; stored entries are not cleared, slots past the count are never compared.
module pending_reply_tracker
   import prt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_handle,
   input  logic [7:0] req_opcode,
   output logic       rsp_valid,
   output logic       rsp_found,
   output logic [7:0] rsp_result_handle,
   output logic       rsp_ready_res,
   output logic [1:0] rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SCAN    = 3'b010,
      ST_COMPACT = 3'b100
   } state_type;

   state_type             state_ff,   state_in;
   key_type               req_ff,     req_in;
   logic [CNT_BITS-1:0]   count_ff,   count_in;
   logic [CNT_BITS-1:0]   idx_ff,     idx_in;
   logic [ADDR_BITS-1:0]  chk_idx_ff, chk_idx_in;
   logic                  pend_ff,    pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff,   found_in;
   logic [7:0]            rhandle_ff, rhandle_in;
   logic                  rdy_ff,     rdy_in;
   status_type            status_ff,  status_in;
   entry_type             rd_ff;

   entry_type             mem [TABLE_DEPTH];
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   entry_type             mem_wdata;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  hit;

   prt_entry_cmp u_cmp (
      .entry (rd_ff),
      .key   (req_ff),
      .hit   (hit)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      chk_idx_in   = chk_idx_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      found_in     = 1'b0;
      rhandle_in   = '0;
      rdy_in       = 1'b0;
      status_in    = STATUS_OK;
      mem_we       = 1'b0;
      mem_waddr    = chk_idx_ff;
      mem_wdata    = rd_ff;
      rd_addr      = idx_ff[ADDR_BITS-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in.kind   = kind_type'(req_kind);
               req_in.handle = HANDLE_BITS'(req_handle);
               req_in.opcode = req_opcode;
               idx_in        = '0;
               pend_in       = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (pend_ff && hit) begin
               case (req_ff.kind)
                  KIND_ADD: begin
                     status_in    = STATUS_DUPLICATE;
                     rsp_valid_in = 1'b1;
                  end
                  KIND_SEARCH: begin
                     found_in     = 1'b1;
                     rhandle_in   = 8'(rd_ff.handle);
                     rsp_valid_in = 1'b1;
                  end
                  KIND_SET_READY: begin
                     mem_we          = 1'b1;
                     mem_wdata.ready = 1'b1;
                     found_in        = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  default: begin
                     if (rd_ff.ready) begin
                        // remove: shift later entries down from this slot
                        idx_in   = CNT_BITS'(chk_idx_ff) + CNT_BITS'(1);
                        pend_in  = 1'b0;
                        state_in = ST_COMPACT;
                     end else begin
                        found_in     = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
               endcase
            end else if (idx_ff == count_ff) begin
               if (req_ff.kind == KIND_ADD) begin
                  if (count_ff == CNT_BITS'(TABLE_DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_we           = 1'b1;
                     mem_waddr        = count_ff[ADDR_BITS-1:0];
                     mem_wdata.handle = req_ff.handle;
                     mem_wdata.opcode = req_ff.opcode;
                     mem_wdata.ready  = 1'b0;
                     count_in         = count_ff + CNT_BITS'(1);
                  end
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
               rsp_valid_in = 1'b1;
            end else begin
               pend_in    = 1'b1;
               chk_idx_in = idx_ff[ADDR_BITS-1:0];
               idx_in     = idx_ff + CNT_BITS'(1);
            end
            if (rsp_valid_in) begin
               state_in = ST_IDLE;
            end
         end

         ST_COMPACT: begin
            // chk_idx_ff is the slot that receives the beat now in rd_ff
            if (pend_ff) begin
               mem_we     = 1'b1;
               chk_idx_in = chk_idx_ff + ADDR_BITS'(1);
            end
            if (idx_ff != count_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CNT_BITS'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in     = count_ff - CNT_BITS'(1);
                  found_in     = 1'b1;
                  rdy_in       = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      if (rsp_valid_in) begin
         found_ff   <= found_in;
         rhandle_ff <= rhandle_in;
         rdy_ff     <= rdy_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_result_handle = rhandle_ff;
   assign rsp_ready_res     = rdy_ff;
   assign rsp_status        = status_ff;

endmodule

FILE: rtl/prt_checker.sv
// Port-level assertions for the pending reply tracker, bound to the top level.
module prt_checker
   import prt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_found,
   input logic [7:0] rsp_result_handle,
   input logic       rsp_ready_res,
   input logic [1:0] rsp_status
);

   // a taken request raises busy
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken but block not busy");

   // busy only ends with a result beat
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one beat");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NOT_FOUND) |->
         !rsp_found && (rsp_result_handle == 8'd0) && !rsp_ready_res)
      else $error("not-found result carries data");

   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready_res |-> rsp_found && (rsp_status == STATUS_OK))
      else $error("removal reported with bad status");

endmodule

bind pending_reply_tracker prt_checker u_prt_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_found         (rsp_found),
   .rsp_result_handle (rsp_result_handle),
   .rsp_ready_res     (rsp_ready_res),
   .rsp_status        (rsp_status)
);
